// ===== hw/rtl/km2d_pkg.sv =====
// ----------------------------------------------------------------------------
// km2d_pkg: shared types and constants for the 2-D k-means block
// Holds the default sizes, the action codes and the sequencer state type.
// ----------------------------------------------------------------------------
package km2d_pkg;

  localparam int DefNumPoints   = 8;
  localparam int DefNumClusters = 3;
  localparam int DefCoordBits   = 8;
  localparam int FracBits       = 8;
  localparam logic [3:0] DefMaxIter = 4'd5;

  localparam logic [1:0] ACT_LOAD_POINT    = 2'd0;
  localparam logic [1:0] ACT_LOAD_CENTROID = 2'd1;
  localparam logic [1:0] ACT_RUN           = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ITER_START,
    ST_DIST,
    ST_SQRT,
    ST_ACCUM,
    ST_DIV_START,
    ST_DIV,
    ST_DIV_DONE,
    ST_ITER_END,
    ST_OUT_LABELS,
    ST_OUT_CENTROIDS
  } state_t;

endpackage

// ===== hw/rtl/kmeans_2d_three_clusters_top.sv =====
// ----------------------------------------------------------------------------
// kmeans_2d_three_clusters_top: Lloyd k-means over stored 2-D points
// Load requests are accepted back to back. A run request walks points and centroids with
// one shared square-root unit and one shared restoring divider.
// ----------------------------------------------------------------------------
// Each distance uses S square-root steps (COORD_BITS+1), and each centroid axis
// uses D divider steps (clog2(P+1) + COORD_BITS + FracBits). A run ends with
// P+K results, one per cycle.
// busy is high for the whole run; results cannot be stalled by the receiver.
// Reset clears labels, centroids and control; max_iterations resets to 5.
module kmeans_2d_three_clusters_top
  import km2d_pkg::*;
#(
  parameter int NUM_POINTS   = DefNumPoints,
  parameter int NUM_CLUSTERS = DefNumClusters,
  parameter int COORD_BITS   = DefCoordBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_slot,
  input  logic [COORD_BITS-1:0] in_coord_x,
  input  logic [COORD_BITS-1:0] in_coord_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        out_strobe,
  output logic        out_kind,
  output logic [2:0]  out_index,
  output logic [1:0]  out_cluster,
  output logic [15:0] out_centroid_x,
  output logic [15:0] out_centroid_y,
  output logic [3:0]  out_iterations_used,
  output logic        out_converged,
  output logic        out_last
);

  localparam int PW  = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int CW  = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int CNW = $clog2(NUM_POINTS + 1);
  localparam int SW  = COORD_BITS + CNW;          // sum width
  localparam int QW  = COORD_BITS + FracBits;     // centroid width
  localparam int NW  = SW + FracBits;             // dividend width
  localparam int DSW = 2 * COORD_BITS + 1;        // squared distance width
  localparam int RW  = COORD_BITS + 1;            // root width
  localparam int SQS = (DSW + 1) / 2;             // root steps
  localparam int SCW = $clog2(NW + 1);

  logic [COORD_BITS-1:0] px_r [NUM_POINTS];
  logic [COORD_BITS-1:0] py_r [NUM_POINTS];
  logic [CW-1:0]         lab_r [NUM_POINTS];
  logic [QW-1:0]         cx_r [NUM_CLUSTERS];
  logic [QW-1:0]         cy_r [NUM_CLUSTERS];
  logic [SW-1:0]         sx_r [NUM_CLUSTERS];
  logic [SW-1:0]         sy_r [NUM_CLUSTERS];
  logic [CNW-1:0]        cnt_r [NUM_CLUSTERS];

  state_t state_r, state_nxt;
  logic [3:0]  max_iter_r, iters_r;
  logic        conv_r, prev_ch_r, ch_r;
  logic [PW-1:0] pi_r;
  logic [CW-1:0] ci_r;
  logic [RW-1:0] best_r;
  logic [CW-1:0] blab_r;
  logic          axis_r;                 // divider works on x (0) or y (1)
  logic [DSW+1:0] rem_r;
  logic [DSW+1:0] rad_r;
  logic [RW:0]   root_r;
  logic [SCW-1:0] step_r;
  logic [NW-1:0] num_r;
  logic [CNW:0]  drem_r;
  logic [QW-1:0] nx_r;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = ~busy;

  // Distance operands for the current point and centroid.
  logic [COORD_BITS-1:0] ccx, ccy, ppx, ppy, dx, dy;
  logic [DSW-1:0] dsq;
  assign ccx = cx_r[ci_r][QW-1:FracBits];
  assign ccy = cy_r[ci_r][QW-1:FracBits];
  assign ppx = px_r[pi_r];
  assign ppy = py_r[pi_r];
  assign dx  = (ccx >= ppx) ? ccx - ppx : ppx - ccx;
  assign dy  = (ccy >= ppy) ? ccy - ppy : ppy - ccy;

  logic [2*COORD_BITS-1:0] dx2_r, dy2_r;
  assign dsq = {1'b0, dx2_r} + {1'b0, dy2_r};

  // One root step: two radicand bits per cycle, trial value is 4*root+1.
  logic [DSW+1:0] trial;
  logic [DSW+1:0] rem_sh;
  assign rem_sh = {rem_r[DSW-1:0], rad_r[DSW+1:DSW]};
  assign trial  = {{(DSW-RW-1){1'b0}}, root_r, 2'b01};

  // One divider step.
  logic [CNW:0] drem_sh;
  logic [CNW-1:0] dcnt;
  assign dcnt    = cnt_r[ci_r];
  assign drem_sh = {drem_r[CNW-1:0], num_r[NW-1]};

  logic last_p, last_c;
  assign last_p = (pi_r == PW'(NUM_POINTS - 1));
  assign last_c = (ci_r == CW'(NUM_CLUSTERS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && in_action == ACT_RUN) begin
          state_nxt = (max_iter_r == 4'd0) ? ST_OUT_LABELS : ST_ITER_START;
        end
      end
      ST_ITER_START: state_nxt = ST_DIST;
      ST_DIST:       state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (step_r == SCW'(SQS - 1)) begin
          state_nxt = (last_c && last_p) ? ST_ACCUM : ST_DIST;
        end
      end
      ST_ACCUM:     if (last_p) state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV;
      ST_DIV:       if (step_r == SCW'(NW - 1)) state_nxt = ST_DIV_DONE;
      ST_DIV_DONE: begin
        if (axis_r && last_c) state_nxt = ST_ITER_END;
        else state_nxt = ST_DIV_START;
      end
      ST_ITER_END: begin
        if ((iters_r >= 4'd2 && !prev_ch_r) || iters_r >= max_iter_r) begin
          state_nxt = ST_OUT_LABELS;
        end else begin
          state_nxt = ST_ITER_START;
        end
      end
      ST_OUT_LABELS:    if (last_p) state_nxt = ST_OUT_CENTROIDS;
      ST_OUT_CENTROIDS: if (last_c) state_nxt = ST_IDLE;
      default:          state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_strobe          = 1'b0;
    out_kind            = 1'b0;
    out_index           = 3'(pi_r);
    out_cluster         = 2'(lab_r[pi_r]);
    out_centroid_x      = '0;
    out_centroid_y      = '0;
    out_iterations_used = iters_r;
    out_converged       = conv_r;
    out_last            = 1'b0;
    case (state_r)
      ST_OUT_LABELS: out_strobe = 1'b1;
      ST_OUT_CENTROIDS: begin
        out_strobe     = 1'b1;
        out_kind       = 1'b1;
        out_index      = 3'(ci_r);
        out_cluster    = '0;
        out_centroid_x = 16'(cx_r[ci_r]);
        out_centroid_y = 16'(cy_r[ci_r]);
        out_last       = last_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      max_iter_r <= DefMaxIter;
      iters_r    <= '0;
      conv_r     <= 1'b0;
      prev_ch_r  <= 1'b1;
      ch_r       <= 1'b0;
      pi_r       <= '0;
      ci_r       <= '0;
      step_r     <= '0;
      axis_r     <= 1'b0;
      for (int i = 0; i < NUM_POINTS; i++) lab_r[i] <= '0;
      for (int k = 0; k < NUM_CLUSTERS; k++) begin
        cx_r[k] <= '0; cy_r[k] <= '0;
        sx_r[k] <= '0; sy_r[k] <= '0; cnt_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (cfg_valid) max_iter_r <= cfg_data;
          if (start) begin
            if (in_action == ACT_LOAD_POINT && 32'(in_slot) < NUM_POINTS) begin
              px_r[PW'(in_slot)] <= in_coord_x;
              py_r[PW'(in_slot)] <= in_coord_y;
            end
            if (in_action == ACT_LOAD_CENTROID && 32'(in_slot) < NUM_CLUSTERS) begin
              cx_r[CW'(in_slot)] <= {in_coord_x, {FracBits{1'b0}}};
              cy_r[CW'(in_slot)] <= {in_coord_y, {FracBits{1'b0}}};
            end
            iters_r   <= '0;
            conv_r    <= 1'b0;
            prev_ch_r <= 1'b1;
            pi_r      <= '0;
            ci_r      <= '0;
          end
        end
        ST_ITER_START: begin
          pi_r <= '0;
          ci_r <= '0;
          ch_r <= 1'b0;
        end
        ST_DIST: begin
          dx2_r  <= {{COORD_BITS{1'b0}}, dx} * {{COORD_BITS{1'b0}}, dx};
          dy2_r  <= {{COORD_BITS{1'b0}}, dy} * {{COORD_BITS{1'b0}}, dy};
          step_r <= '0;
          rem_r  <= '0;
          root_r <= '0;
          rad_r  <= '0;
        end
        ST_SQRT: begin
          if (step_r == '0) begin
            // First step loads the radicand and consumes its lone top bit.
            rad_r  <= {dsq[DSW-2:0], 3'b000};
            rem_r  <= '0;
            root_r <= {{RW{1'b0}}, dsq[DSW-1]};
          end else begin
            rad_r <= rad_r << 2;
            if (rem_sh >= trial) begin
              rem_r  <= rem_sh - trial;
              root_r <= {root_r[RW-1:0], 1'b1};
            end else begin
              rem_r  <= rem_sh;
              root_r <= {root_r[RW-1:0], 1'b0};
            end
          end
          step_r <= step_r + 1'b1;
          if (step_r == SCW'(SQS - 1)) begin
            begin : pick
              logic [RW-1:0] r;
              r = (rem_sh >= trial) ? {root_r[RW-2:0], 1'b1} : {root_r[RW-2:0], 1'b0};
              if (ci_r == '0 || r <= best_r) begin
                best_r <= r;
                blab_r <= ci_r;
                if (last_c) lab_r[pi_r] <= ci_r;
              end else if (last_c) begin
                lab_r[pi_r] <= blab_r;
              end
            end
            if (last_c) begin
              ci_r <= '0;
              pi_r <= last_p ? '0 : pi_r + 1'b1;
            end else begin
              ci_r <= ci_r + 1'b1;
            end
            if (last_c && last_p) begin
              for (int k = 0; k < NUM_CLUSTERS; k++) begin
                sx_r[k] <= '0; sy_r[k] <= '0; cnt_r[k] <= '0;
              end
            end
          end
        end
        ST_ACCUM: begin
          sx_r[lab_r[pi_r]]  <= sx_r[lab_r[pi_r]] + SW'(ppx);
          sy_r[lab_r[pi_r]]  <= sy_r[lab_r[pi_r]] + SW'(ppy);
          cnt_r[lab_r[pi_r]] <= cnt_r[lab_r[pi_r]] + 1'b1;
          pi_r <= last_p ? '0 : pi_r + 1'b1;
          ci_r <= '0;
          axis_r <= 1'b0;
        end
        ST_DIV_START: begin
          num_r  <= {axis_r ? sy_r[ci_r] : sx_r[ci_r], {FracBits{1'b0}}};
          drem_r <= '0;
          step_r <= '0;
        end
        ST_DIV: begin
          if (drem_sh >= {1'b0, dcnt}) begin
            drem_r <= drem_sh - {1'b0, dcnt};
            num_r  <= {num_r[NW-2:0], 1'b1};
          end else begin
            drem_r <= drem_sh;
            num_r  <= {num_r[NW-2:0], 1'b0};
          end
          step_r <= step_r + 1'b1;
        end
        ST_DIV_DONE: begin
          if (!axis_r) begin
            nx_r   <= QW'(num_r);
            axis_r <= 1'b1;
          end else begin
            if (dcnt != '0) begin
              if (nx_r != cx_r[ci_r] || QW'(num_r) != cy_r[ci_r]) ch_r <= 1'b1;
              cx_r[ci_r] <= nx_r;
              cy_r[ci_r] <= QW'(num_r);
            end
            axis_r <= 1'b0;
            ci_r   <= last_c ? '0 : ci_r + 1'b1;
            if (last_c) iters_r <= iters_r + 1'b1;
          end
        end
        ST_ITER_END: begin
          if (iters_r >= 4'd2 && !prev_ch_r) conv_r <= 1'b1;
          prev_ch_r <= ch_r;
          pi_r <= '0;
          ci_r <= '0;
        end
        ST_OUT_LABELS: begin
          pi_r <= last_p ? '0 : pi_r + 1'b1;
          ci_r <= '0;
        end
        ST_OUT_CENTROIDS: ci_r <= last_c ? '0 : ci_r + 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 2-D k-means block
// Loads points and centroids, starts clustering runs under several iteration
// limits, predicts every label and centroid result and checks each strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import km2d_pkg::*;

  localparam int NPTS = 8;
  localparam int NCL = 3;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        kind;
    logic [2:0]  index;
    logic [1:0]  cluster;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [3:0]  iters;
    logic        conv;
    logic        last;
  } km_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [2:0] in_slot = '0;
  logic [7:0] in_coord_x = '0;
  logic [7:0] in_coord_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  logic out_strobe, out_kind, out_converged, out_last;
  logic [2:0] out_index;
  logic [1:0] out_cluster;
  logic [15:0] out_centroid_x, out_centroid_y;
  logic [3:0] out_iterations_used;

  kmeans_2d_three_clusters_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_slot(in_slot),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_kind(out_kind), .out_index(out_index),
    .out_cluster(out_cluster), .out_centroid_x(out_centroid_x),
    .out_centroid_y(out_centroid_y), .out_iterations_used(out_iterations_used),
    .out_converged(out_converged), .out_last(out_last)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block's state.
  logic [7:0]  pt_x [NPTS];
  logic [7:0]  pt_y [NPTS];
  logic [1:0]  labels [NPTS];
  logic [15:0] cen_x [NCL];
  logic [15:0] cen_y [NCL];
  logic [3:0]  iter_limit;

  km_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int pending_gap = 0;
  int items_sent = 0;

  function automatic int isqrt(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int absdiff(int a, int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // One assign-and-update pass; returns 1 if any centroid moved.
  function automatic bit lloyd_pass();
    int best, d, dx, dy, nx, ny;
    int sx [NCL];
    int sy [NCL];
    int cnt [NCL];
    bit moved;
    moved = 0;
    for (int p = 0; p < NPTS; p++) begin
      best = 0;
      for (int c = 0; c < NCL; c++) begin
        dx = absdiff(int'(cen_x[c] >> 8), int'(pt_x[p]));
        dy = absdiff(int'(cen_y[c] >> 8), int'(pt_y[p]));
        d = isqrt(dx * dx + dy * dy);
        // Ties resolve toward the higher-numbered centroid.
        if (c == 0 || d <= best) begin
          best = d;
          labels[p] = 2'(c);
        end
      end
    end
    for (int c = 0; c < NCL; c++) begin
      sx[c] = 0; sy[c] = 0; cnt[c] = 0;
    end
    for (int p = 0; p < NPTS; p++) begin
      sx[labels[p]] += pt_x[p];
      sy[labels[p]] += pt_y[p];
      cnt[labels[p]] += 1;
    end
    for (int c = 0; c < NCL; c++) begin
      if (cnt[c] != 0) begin
        nx = (sx[c] << 8) / cnt[c];
        ny = (sy[c] << 8) / cnt[c];
        if (nx != cen_x[c] || ny != cen_y[c]) moved = 1;
        cen_x[c] = 16'(nx);
        cen_y[c] = 16'(ny);
      end
    end
    return moved;
  endfunction

  task automatic predict_request(logic [1:0] act, logic [2:0] slot,
                                 logic [7:0] x, logic [7:0] y);
    int iters;
    bit conv, prev_moved, moved;
    km_result_t r;
    iters = 0; conv = 0; prev_moved = 1;
    if (act == ACT_LOAD_POINT) begin
      pt_x[slot] = x;
      pt_y[slot] = y;
    end else if (act == ACT_LOAD_CENTROID) begin
      if (slot < NCL) begin
        cen_x[slot] = {x, 8'h00};
        cen_y[slot] = {y, 8'h00};
      end
    end else if (act == ACT_RUN) begin
      while (iters < iter_limit) begin
        moved = lloyd_pass();
        iters++;
        if (iters >= 2 && !prev_moved) begin
          conv = 1;
          break;
        end
        prev_moved = moved;
      end
      for (int p = 0; p < NPTS; p++) begin
        r = '{kind: 1'b0, index: 3'(p), cluster: labels[p], cx: '0, cy: '0,
              iters: 4'(iters), conv: conv, last: 1'b0};
        expected_results.push_back(r);
      end
      for (int c = 0; c < NCL; c++) begin
        r = '{kind: 1'b1, index: 3'(c), cluster: '0, cx: cen_x[c], cy: cen_y[c],
              iters: 4'(iters), conv: conv, last: (c == NCL - 1)};
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic send_request(logic [1:0] act, logic [2:0] slot,
                              logic [7:0] x, logic [7:0] y);
    repeat (pending_gap) @(posedge clk);
    start <= 1'b1;
    in_action <= act;
    in_slot <= slot;
    in_coord_x <= x;
    in_coord_y <= y;
    do @(posedge clk); while (busy);
    predict_request(act, slot, x, y);
    items_sent++;
    // Drop start only when a gap follows, so it is never lowered and raised
    // in the same step.
    pending_gap = $urandom_range(0, 3);
    if (pending_gap != 0) start <= 1'b0;
  endtask

  // Let the block go quiet before touching the register.
  task automatic wait_idle();
    if (pending_gap == 0) begin
      start <= 1'b0;
      @(posedge clk);
    end
    pending_gap = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_iter_limit(logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    iter_limit = v;
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    km_result_t w;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_index, -1);
      end else begin
        w = expected_results.pop_front();
        if (out_kind != w.kind) report_mismatch("kind", out_kind, w.kind);
        if (out_index != w.index) report_mismatch("index", out_index, w.index);
        if (out_cluster != w.cluster) report_mismatch("cluster", out_cluster, w.cluster);
        if (out_centroid_x != w.cx) report_mismatch("centroid_x", out_centroid_x, w.cx);
        if (out_centroid_y != w.cy) report_mismatch("centroid_y", out_centroid_y, w.cy);
        if (out_iterations_used != w.iters)
          report_mismatch("iterations_used", out_iterations_used, w.iters);
        if (out_converged != w.conv) report_mismatch("converged", out_converged, w.conv);
        if (out_last != w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_basic_run();
    send_request(ACT_LOAD_POINT, 3'd0, 8'd0, 8'd0);
    send_request(ACT_LOAD_POINT, 3'd1, 8'd255, 8'd255);
    send_request(ACT_LOAD_POINT, 3'd2, 8'd0, 8'd255);
    send_request(ACT_LOAD_POINT, 3'd3, 8'd255, 8'd0);
    send_request(ACT_LOAD_POINT, 3'd4, 8'd10, 8'd12);
    send_request(ACT_LOAD_POINT, 3'd5, 8'd240, 8'd250);
    send_request(ACT_LOAD_POINT, 3'd6, 8'd128, 8'd127);
    send_request(ACT_LOAD_POINT, 3'd7, 8'd5, 8'd250);
    send_request(ACT_LOAD_CENTROID, 3'd0, 8'd0, 8'd0);
    send_request(ACT_LOAD_CENTROID, 3'd1, 8'd255, 8'd255);
    send_request(ACT_LOAD_CENTROID, 3'd2, 8'd128, 8'd128);
    send_request(ACT_RUN, 3'd0, 8'd0, 8'd0);
    wait_idle();
  endtask

  task automatic test_ignored_requests();
    send_request(ACT_UNUSED, 3'd1, 8'd200, 8'd3);
    send_request(ACT_LOAD_CENTROID, 3'd7, 8'd1, 8'd2);
    send_request(ACT_LOAD_CENTROID, 3'd3, 8'd99, 8'd99);
    send_request(ACT_RUN, 3'd5, 8'd17, 8'd34);
    wait_idle();
  endtask

  // Two identical centroids tie on every point; the first pass leaves centroid 0 empty.
  task automatic test_tie_and_empty();
    send_request(ACT_LOAD_CENTROID, 3'd0, 8'd60, 8'd60);
    send_request(ACT_LOAD_CENTROID, 3'd1, 8'd60, 8'd60);
    send_request(ACT_LOAD_CENTROID, 3'd2, 8'd255, 8'd0);
    send_request(ACT_RUN, 3'd0, 8'd0, 8'd0);
    wait_idle();
  endtask

  task automatic test_iteration_limits();
    write_iter_limit(4'd0);
    send_request(ACT_RUN, 3'd0, 8'd0, 8'd0);
    wait_idle();
    write_iter_limit(4'd15);
    send_request(ACT_LOAD_CENTROID, 3'd0, 8'd1, 8'd254);
    send_request(ACT_RUN, 3'd0, 8'd0, 8'd0);
    wait_idle();
    write_iter_limit(4'd1);
    send_request(ACT_RUN, 3'd0, 8'd0, 8'd0);
    wait_idle();
  endtask

  task automatic test_random_runs();
    int burst;
    int pick;
    logic [3:0] lim;
    while (items_sent < 245) begin
      pick = $urandom_range(0, 5);
      lim = (pick == 0) ? 4'd15 : (pick == 1) ? 4'd1 : (pick == 2) ? 4'd0 :
            4'($urandom_range(1, 15));
      write_iter_limit(lim);
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 11)
          send_request(ACT_LOAD_POINT, 3'($urandom_range(0, 7)),
                       8'($urandom), 8'($urandom));
        else if (pick < 16)
          send_request(ACT_LOAD_CENTROID, 3'($urandom_range(0, 2)),
                       8'($urandom), 8'($urandom));
        else if (pick < 18)
          send_request(ACT_LOAD_CENTROID, 3'($urandom_range(3, 7)),
                       8'($urandom), 8'($urandom));
        else
          send_request(ACT_UNUSED, 3'($urandom), 8'($urandom), 8'($urandom));
      end
      send_request(ACT_RUN, 3'($urandom), 8'($urandom), 8'($urandom));
      wait_idle();
    end
  endtask

  initial begin
    for (int p = 0; p < NPTS; p++) begin
      pt_x[p] = '0; pt_y[p] = '0; labels[p] = '0;
    end
    for (int c = 0; c < NCL; c++) begin
      cen_x[c] = '0; cen_y[c] = '0;
    end
    iter_limit = DefMaxIter;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_run();
    test_ignored_requests();
    test_tie_and_empty();
    test_iteration_limits();
    test_random_runs();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/km2d_pkg.sv
hw/rtl/kmeans_2d_three_clusters_top.sv
verif/testbench.sv
